// ===== src/vrd_pkg.sv =====
`timescale 1ns / 1ps
package vrd_pkg;

   localparam int WORD_BITS  = 32;
   localparam int UNIT_BITS  = 30;
   localparam int NORM_BITS  = UNIT_BITS + 1;
   localparam int SQ_BITS    = 2 * NORM_BITS;
   localparam int ROOT_BITS  = NORM_BITS + 1;
   localparam int REM_BITS   = 2 * ROOT_BITS + 2;
   localparam int QUO_BITS   = UNIT_BITS + 1;
   localparam int PROD_BITS  = WORD_BITS + QUO_BITS + 1;
   localparam int ACC_BITS   = PROD_BITS + 1;
   localparam int RND_BITS   = ACC_BITS - UNIT_BITS;
   localparam int POS_BITS   = $clog2(WORD_BITS);
   localparam int SH_BITS    = $clog2(WORD_BITS + UNIT_BITS);
   localparam int MIDQ_DEPTH = 4;
   localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
   localparam int OUTQ_DEPTH = 128;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

   typedef struct packed {
      logic signed [WORD_BITS-1:0] point_x;
      logic signed [WORD_BITS-1:0] point_y;
      logic signed [WORD_BITS-1:0] dir_x;
      logic signed [WORD_BITS-1:0] dir_y;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] rotated_x;
      logic signed [WORD_BITS-1:0] rotated_y;
      logic                        saturated;
      logic                        zero_direction;
   } rsp_type;

   // classified item: point, direction signs and magnitudes, zero flag
   typedef struct packed {
      logic signed [WORD_BITS-1:0] px;
      logic signed [WORD_BITS-1:0] py;
      logic                        sgx;
      logic                        sgy;
      logic        [WORD_BITS-1:0] ma;
      logic        [WORD_BITS-1:0] mb;
      logic                        zero;
   } cls_type;

   // fields that ride along the back pipeline
   typedef struct packed {
      logic signed [WORD_BITS-1:0] px;
      logic signed [WORD_BITS-1:0] py;
      logic                        sgx;
      logic                        sgy;
      logic                        zero;
   } ctx_type;

   typedef struct packed {
      logic    valid;
      cls_type item;
   } head_type;

endpackage

// ===== src/vrd_front.sv =====
`timescale 1ns / 1ps
module vrd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  vrd_pkg::req_type req_data,
   output vrd_pkg::head_type head,
   input  logic             take
);
   import vrd_pkg::*;

   cls_type                cls;
   cls_type                q_ff [MIDQ_DEPTH];
   logic [MIDQ_AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [MIDQ_AW:0]       cnt_ff, cnt_in;
   logic                   wr, rd;

   // classify: split direction into sign and magnitude, flag zero direction
   always_comb begin
      cls.px   = req_data.point_x;
      cls.py   = req_data.point_y;
      cls.sgx  = req_data.dir_x[WORD_BITS-1];
      cls.sgy  = req_data.dir_y[WORD_BITS-1];
      cls.ma   = cls.sgx ? WORD_BITS'(-req_data.dir_x) : WORD_BITS'(req_data.dir_x);
      cls.mb   = cls.sgy ? WORD_BITS'(-req_data.dir_y) : WORD_BITS'(req_data.dir_y);
      cls.zero = (req_data.dir_x == '0) && (req_data.dir_y == '0);
   end

   assign full       = (cnt_ff == (MIDQ_AW+1)'(MIDQ_DEPTH));
   assign wr         = push && !full;
   assign rd         = take && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + MIDQ_AW'(wr);
      rd_ptr_in = rd_ptr_ff + MIDQ_AW'(rd);
      cnt_in    = cnt_ff + (MIDQ_AW+1)'(wr) - (MIDQ_AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (wr) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== src/vrd_back.sv =====
`timescale 1ns / 1ps
module vrd_back (
   input  logic              clock,
   input  logic              reset,
   input  vrd_pkg::head_type head,
   output logic              take,
   input  logic              credit,
   output logic              res_valid,
   output vrd_pkg::rsp_type  res_data
);
   import vrd_pkg::*;

   // normalize stage
   logic [WORD_BITS-1:0]        m;
   logic [POS_BITS-1:0]         pos;
   logic [SH_BITS-1:0]          lsh, rsh;
   logic [WORD_BITS+NORM_BITS-1:0] ea, eb;
   logic [NORM_BITS-1:0]        an, bn;
   logic                        n_v_ff;
   ctx_type                     n_ctx_ff;
   logic [NORM_BITS-1:0]        n_a_ff, n_b_ff;

   // square stage
   logic                        s_v_ff;
   ctx_type                     s_ctx_ff;
   logic [NORM_BITS-1:0]        s_a_ff, s_b_ff;
   logic [SQ_BITS-1:0]          s_aa_ff, s_bb_ff;

   // root pipeline, index 0 feeds the first bit stage
   logic                        q_v  [ROOT_BITS+1];
   ctx_type                     q_ctx[ROOT_BITS+1];
   logic [NORM_BITS-1:0]        q_a  [ROOT_BITS+1];
   logic [NORM_BITS-1:0]        q_b  [ROOT_BITS+1];
   logic [REM_BITS-1:0]         q_rem[ROOT_BITS+1];
   logic [ROOT_BITS-1:0]        q_rt [ROOT_BITS+1];

   // divide pipeline, both quotients in lockstep
   logic                        d_v  [QUO_BITS+1];
   ctx_type                     d_ctx[QUO_BITS+1];
   logic [ROOT_BITS-1:0]        d_r  [QUO_BITS+1];
   logic [REM_BITS-1:0]         d_ra [QUO_BITS+1];
   logic [REM_BITS-1:0]         d_rb [QUO_BITS+1];
   logic [QUO_BITS-1:0]         d_qa [QUO_BITS+1];
   logic [QUO_BITS-1:0]         d_qb [QUO_BITS+1];

   // multiply stage
   logic signed [QUO_BITS:0]    ux, uy;
   logic                        p_v_ff;
   logic                        p_zero_ff;
   logic signed [PROD_BITS-1:0] p_xx_ff, p_yy_ff, p_xy_ff, p_yx_ff;

   // finish
   logic signed [ACC_BITS-1:0]  acc_x, acc_y;
   logic signed [RND_BITS-1:0]  rnd_x, rnd_y;
   logic                        ok_x, ok_y;

   assign take = head.valid && credit;

   always_comb begin
      m   = (head.item.ma > head.item.mb) ? head.item.ma : head.item.mb;
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (m[i]) pos = POS_BITS'(i);
      end
      lsh = SH_BITS'(UNIT_BITS) - SH_BITS'(pos);
      rsh = SH_BITS'(pos) - SH_BITS'(UNIT_BITS);
      ea  = (WORD_BITS+NORM_BITS)'(head.item.ma);
      eb  = (WORD_BITS+NORM_BITS)'(head.item.mb);
      if (SH_BITS'(pos) <= SH_BITS'(UNIT_BITS)) begin
         an = NORM_BITS'(ea << lsh);
         bn = NORM_BITS'(eb << lsh);
      end else begin
         an = NORM_BITS'(ea >> rsh);
         bn = NORM_BITS'(eb >> rsh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
      end else begin
         n_v_ff <= take;
         s_v_ff <= n_v_ff;
      end
      n_ctx_ff.px   <= head.item.px;
      n_ctx_ff.py   <= head.item.py;
      n_ctx_ff.sgx  <= head.item.sgx;
      n_ctx_ff.sgy  <= head.item.sgy;
      n_ctx_ff.zero <= head.item.zero;
      n_a_ff        <= an;
      n_b_ff        <= bn;
      s_ctx_ff      <= n_ctx_ff;
      s_a_ff        <= n_a_ff;
      s_b_ff        <= n_b_ff;
      s_aa_ff       <= SQ_BITS'(n_a_ff) * SQ_BITS'(n_a_ff);
      s_bb_ff       <= SQ_BITS'(n_b_ff) * SQ_BITS'(n_b_ff);
   end

   assign q_v[0]   = s_v_ff;
   assign q_ctx[0] = s_ctx_ff;
   assign q_a[0]   = s_a_ff;
   assign q_b[0]   = s_b_ff;
   assign q_rem[0] = REM_BITS'(s_aa_ff) + REM_BITS'(s_bb_ff);
   assign q_rt[0]  = '0;

   // one root bit per stage, most significant first
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      localparam int BIT = ROOT_BITS - 1 - k;
      logic [REM_BITS-1:0] trial;
      logic                hit;
      assign trial = (REM_BITS'(q_rt[k]) << (BIT + 1)) | (REM_BITS'(1) << (2 * BIT));
      assign hit   = (q_rem[k] >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            q_v[k+1] <= 1'b0;
         end else begin
            q_v[k+1] <= q_v[k];
         end
         q_ctx[k+1] <= q_ctx[k];
         q_a[k+1]   <= q_a[k];
         q_b[k+1]   <= q_b[k];
         q_rem[k+1] <= hit ? q_rem[k] - trial : q_rem[k];
         q_rt[k+1]  <= hit ? (q_rt[k] | (ROOT_BITS'(1) << BIT)) : q_rt[k];
      end
   end

   assign d_v[0]   = q_v[ROOT_BITS];
   assign d_ctx[0] = q_ctx[ROOT_BITS];
   assign d_r[0]   = q_rt[ROOT_BITS];
   assign d_ra[0]  = REM_BITS'(q_a[ROOT_BITS]) << UNIT_BITS;
   assign d_rb[0]  = REM_BITS'(q_b[ROOT_BITS]) << UNIT_BITS;
   assign d_qa[0]  = '0;
   assign d_qb[0]  = '0;

   // one quotient bit per stage; quotients never exceed the unit
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      localparam int BIT = QUO_BITS - 1 - k;
      logic [REM_BITS-1:0] dsr;
      logic                ha, hb;
      assign dsr = REM_BITS'(d_r[k]) << BIT;
      assign ha  = (d_ra[k] >= dsr);
      assign hb  = (d_rb[k] >= dsr);
      always_ff @(posedge clock) begin
         if (reset) begin
            d_v[k+1] <= 1'b0;
         end else begin
            d_v[k+1] <= d_v[k];
         end
         d_ctx[k+1] <= d_ctx[k];
         d_r[k+1]   <= d_r[k];
         d_ra[k+1]  <= ha ? d_ra[k] - dsr : d_ra[k];
         d_rb[k+1]  <= hb ? d_rb[k] - dsr : d_rb[k];
         d_qa[k+1]  <= ha ? (d_qa[k] | (QUO_BITS'(1) << BIT)) : d_qa[k];
         d_qb[k+1]  <= hb ? (d_qb[k] | (QUO_BITS'(1) << BIT)) : d_qb[k];
      end
   end

   always_comb begin
      ux = $signed({1'b0, d_qa[QUO_BITS]});
      uy = $signed({1'b0, d_qb[QUO_BITS]});
      if (d_ctx[QUO_BITS].sgx) ux = -ux;
      if (d_ctx[QUO_BITS].sgy) uy = -uy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else begin
         p_v_ff <= d_v[QUO_BITS];
      end
      p_zero_ff <= d_ctx[QUO_BITS].zero;
      p_xx_ff   <= PROD_BITS'(d_ctx[QUO_BITS].px) * PROD_BITS'(ux);
      p_yy_ff   <= PROD_BITS'(d_ctx[QUO_BITS].py) * PROD_BITS'(uy);
      p_xy_ff   <= PROD_BITS'(d_ctx[QUO_BITS].px) * PROD_BITS'(uy);
      p_yx_ff   <= PROD_BITS'(d_ctx[QUO_BITS].py) * PROD_BITS'(ux);
   end

   // round half up, drop the unit scale, clamp to the word; zero direction gives zeros
   always_comb begin
      acc_x = ACC_BITS'(p_xx_ff) - ACC_BITS'(p_yy_ff)
              + (ACC_BITS'(1) << (UNIT_BITS - 1));
      acc_y = ACC_BITS'(p_xy_ff) + ACC_BITS'(p_yx_ff)
              + (ACC_BITS'(1) << (UNIT_BITS - 1));
      rnd_x = RND_BITS'(acc_x >>> UNIT_BITS);
      rnd_y = RND_BITS'(acc_y >>> UNIT_BITS);
      ok_x  = (rnd_x[RND_BITS-1:WORD_BITS-1] == '0) || (rnd_x[RND_BITS-1:WORD_BITS-1] == '1);
      ok_y  = (rnd_y[RND_BITS-1:WORD_BITS-1] == '0) || (rnd_y[RND_BITS-1:WORD_BITS-1] == '1);
      res_valid = p_v_ff;
      res_data.zero_direction = p_zero_ff;
      if (p_zero_ff) begin
         res_data.rotated_x = '0;
         res_data.rotated_y = '0;
         res_data.saturated = 1'b0;
      end else begin
         res_data.rotated_x = ok_x ? WORD_BITS'(rnd_x)
                            : (rnd_x[RND_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                                 : {1'b0, {(WORD_BITS-1){1'b1}}});
         res_data.rotated_y = ok_y ? WORD_BITS'(rnd_y)
                            : (rnd_y[RND_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                                 : {1'b0, {(WORD_BITS-1){1'b1}}});
         res_data.saturated = !(ok_x && ok_y);
      end
   end

endmodule

// ===== src/vrd_outq.sv =====
`timescale 1ns / 1ps
module vrd_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             issue,
   output logic             credit,
   input  logic             wr,
   input  vrd_pkg::rsp_type wr_data,
   output logic             empty,
   input  logic             pop,
   output vrd_pkg::rsp_type rsp_data
);
   import vrd_pkg::*;

   rsp_type              mem [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUTQ_AW:0]     mem_cnt_ff, mem_cnt_in;
   logic [OUTQ_AW:0]     occ_ff, occ_in;
   logic                 out_v_ff;
   rsp_type              out_ff;
   logic                 load, deq;

   // occupancy counts reserved slots: in flight, stored and on the ports
   assign credit = (occ_ff < (OUTQ_AW+1)'(OUTQ_DEPTH));
   assign empty  = !out_v_ff;
   assign deq    = pop && out_v_ff;
   assign load   = (mem_cnt_ff != '0) && (!out_v_ff || deq);
   assign rsp_data = out_ff;

   always_comb begin
      occ_in     = occ_ff + (OUTQ_AW+1)'(issue) - (OUTQ_AW+1)'(deq);
      mem_cnt_in = mem_cnt_ff + (OUTQ_AW+1)'(wr) - (OUTQ_AW+1)'(load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         mem_cnt_ff <= '0;
         occ_ff     <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_ff + OUTQ_AW'(wr);
         rd_ptr_ff  <= rd_ptr_ff + OUTQ_AW'(load);
         mem_cnt_ff <= mem_cnt_in;
         occ_ff     <= occ_in;
         if (load) begin
            out_v_ff <= 1'b1;
         end else if (deq) begin
            out_v_ff <= 1'b0;
         end
      end
      if (wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (load) begin
         out_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

// ===== src/vector_rotate_by_direction.sv =====
`timescale 1ns / 1ps
// Rotates a Q16.16 point by the angle of a Q16.16 direction vector.
// Request side is a queue write port: a transaction is taken on a rising
// edge with push high and full low; req_data carries point and direction.
// Response side is a queue read port: while empty is low, rsp_data holds
// the oldest result; pop high at an edge takes it.
// Every request yields exactly one response, in order.
// Stages from push to empty going low: normalize, square, 32 root bit
// stages, 31 divide stages, multiply, output queue.
// Throughput: one transaction per cycle while response slots are free;
// the root and divide pipelines each retire one bit per stage for every
// item in flight. A stalled receiver fills the 128-entry response queue;
// the back end issues only against free slots there, then the small
// request queue fills and full rises. Nothing is lost or repeated.
// Reset empties both queues and the pipelines; no clearing pass is needed.
// A zero direction returns zeros with zero_direction set; results that do
// not fit the word clamp and set saturated.
module vector_rotate_by_direction (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  vrd_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output vrd_pkg::rsp_type rsp_data
);
   import vrd_pkg::*;

   head_type head;
   logic     take;
   logic     credit;
   logic     res_valid;
   rsp_type  res_data;

   // front: accept and classify, hold in the request queue
   vrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .head     (head),
      .take     (take)
   );

   // back: normalize, root, divide, multiply, round and clamp
   vrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .take      (take),
      .credit    (credit),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // response queue; advance only against reserved slots
   vrd_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .issue    (take),
      .credit   (credit),
      .wr       (res_valid),
      .wr_data  (res_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
